### rtl/kswe_pkg.sv
// Package for the rolling 2-bit k-mer extractor.
// Holds widths, register indexes and the k-mer mask function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kswe_pkg;

    localparam int unsigned MAX_K     = 31;
    localparam int unsigned KMER_W    = 62;
    localparam int unsigned K_W       = 5;
    localparam int unsigned RUN_W     = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 80;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned APB_W     = 32;

    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] REG_KMER_LENGTH    = 2'd0;
    localparam logic [1:0] REG_QUALITY_CUTOFF = 2'd1;
    localparam logic [1:0] REG_HOMO_ENABLE    = 2'd2;
    localparam logic [1:0] REG_HOMO_CUTOFF    = 2'd3;

    localparam logic [K_W-1:0]   KMER_LENGTH_RESET = K_W'(MAX_K);
    localparam logic [RUN_W-1:0] HOMO_CUTOFF_RESET = 8'd255;

    // Low 2k bits set.
    function automatic logic [KMER_W-1:0] kmer_mask(input logic [K_W-1:0] k);
        logic [KMER_W-1:0] m;
        logic [K_W:0]      twok;
        twok = {k, 1'b0};
        for (int i = 0; i < KMER_W; i++) begin
            m[i] = (i < int'(twok));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/kmer_sliding_window_extractor.sv
// Rolling 2-bit k-mer extractor: one base in, one result out.
// Depends on kswe_pkg.
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata {quality, base}, tuser known, tlast read end
// m_        out  m_tvalid/m_tready  tdata {count, kmer}, tuser {start, valid}, tlast
// apb       in   psel/penable       four config registers at 0x0..0xC
//
// One base per cycle while s_tready is high; the result appears in the output
// register in the cycle after the request is accepted. The whole window update
// is one pass between the state registers and the output register. s_tready
// drops only while a result is held and m_tready is low. aresetn is synchronous;
// it clears state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module kmer_sliding_window_extractor (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [kswe_pkg::S_DATA_W-1:0]    s_tdata,   // base[1:0], quality[9:2], zero
    input  wire  [0:0]                       s_tuser,   // base_known[0]
    input  wire                              s_tlast,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [kswe_pkg::M_DATA_W-1:0]    m_tdata,   // kmer[61:0], kmer_count[77:62], zero
    output logic [1:0]                       m_tuser,   // kmer_valid[0], window_start[1]
    output logic                             m_tlast,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [kswe_pkg::ADDR_W-1:0]      paddr,
    input  wire  [kswe_pkg::APB_W-1:0]       pwdata,
    output logic [kswe_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);

    logic [kswe_pkg::K_W-1:0]     kmer_length_reg;
    logic [kswe_pkg::RUN_W-1:0]   quality_cutoff_reg;
    logic                         homo_enable_reg;
    logic [kswe_pkg::RUN_W-1:0]   homo_cutoff_reg;

    logic [kswe_pkg::KMER_W-1:0]  rolling_kmer_reg, rolling_kmer_next;
    logic [kswe_pkg::K_W-1:0]     good_bases_reg, good_bases_next;
    logic [kswe_pkg::RUN_W-1:0]   run_length_reg, run_length_next;
    logic [1:0]                   previous_base_reg, previous_base_next;
    logic                         skipping_reg, skipping_next;
    logic [1:0]                   skip_base_reg, skip_base_next;
    logic [kswe_pkg::COUNT_W-1:0] total_reg, total_next;

    logic                         m_tvalid_reg;
    logic [kswe_pkg::KMER_W-1:0]  out_kmer_reg, out_kmer_next;
    logic [kswe_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_start_reg, out_start_next;
    logic                         out_last_reg;

    logic                         s_accept;
    logic                         cfg_write;
    logic [1:0]                   base;
    logic                         known;
    logic [7:0]                   quality;
    logic [kswe_pkg::K_W-1:0]     k_eff;
    logic [kswe_pkg::RUN_W-1:0]   run;
    logic                         handle;
    logic                         bad;
    logic                         homo;
    logic [kswe_pkg::KMER_W-1:0]  shifted;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    assign base    = s_tdata[1:0];
    assign quality = s_tdata[9:2];
    assign known   = s_tuser[0];
    assign k_eff   = (kmer_length_reg == '0) ? kswe_pkg::K_W'(1) : kmer_length_reg;

    always_comb begin
        case (paddr[3:2])
            kswe_pkg::REG_KMER_LENGTH:    prdata = 32'(kmer_length_reg);
            kswe_pkg::REG_QUALITY_CUTOFF: prdata = 32'(quality_cutoff_reg);
            kswe_pkg::REG_HOMO_ENABLE:    prdata = 32'(homo_enable_reg);
            kswe_pkg::REG_HOMO_CUTOFF:    prdata = 32'(homo_cutoff_reg);
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        rolling_kmer_next  = rolling_kmer_reg;
        good_bases_next    = good_bases_reg;
        run_length_next    = run_length_reg;
        previous_base_next = previous_base_reg;
        skipping_next      = skipping_reg;
        skip_base_next     = skip_base_reg;
        total_next         = total_reg;
        out_valid_next     = 1'b0;
        out_start_next     = 1'b0;
        out_kmer_next      = '0;

        handle = !(skipping_reg && known && (base == skip_base_reg));
        if (skipping_reg && handle) begin
            skipping_next = 1'b0;
        end

        if ((good_bases_reg != '0) && (base == previous_base_reg)) begin
            run = (run_length_reg == kswe_pkg::RUN_MAX) ? kswe_pkg::RUN_MAX
                                                        : run_length_reg + 8'd1;
        end else begin
            run = 8'd1;
        end

        bad     = !known || ((quality_cutoff_reg != '0) && (quality <= quality_cutoff_reg));
        homo    = homo_enable_reg && (run >= homo_cutoff_reg);
        shifted = {rolling_kmer_reg[kswe_pkg::KMER_W-3:0], base}
                  & kswe_pkg::kmer_mask(k_eff);

        if (handle) begin
            if (bad) begin
                good_bases_next = '0;
                run_length_next = '0;
            end else if (homo) begin
                good_bases_next = '0;
                run_length_next = '0;
                skipping_next   = 1'b1;
                skip_base_next  = base;
            end else begin
                run_length_next    = run;
                previous_base_next = base;
                rolling_kmer_next  = shifted;
                if (good_bases_reg >= k_eff) begin
                    good_bases_next = k_eff;
                    out_valid_next  = 1'b1;
                end else begin
                    good_bases_next = good_bases_reg + 5'd1;
                    if (good_bases_next == k_eff) begin
                        out_valid_next = 1'b1;
                        out_start_next = 1'b1;
                    end
                end
                if (out_valid_next) begin
                    out_kmer_next = shifted;
                    if (total_reg != kswe_pkg::COUNT_MAX) begin
                        total_next = total_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg    <= kswe_pkg::KMER_LENGTH_RESET;
            quality_cutoff_reg <= '0;
            homo_enable_reg    <= 1'b0;
            homo_cutoff_reg    <= kswe_pkg::HOMO_CUTOFF_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                kswe_pkg::REG_KMER_LENGTH:    kmer_length_reg    <= pwdata[4:0];
                kswe_pkg::REG_QUALITY_CUTOFF: quality_cutoff_reg <= pwdata[7:0];
                kswe_pkg::REG_HOMO_ENABLE:    homo_enable_reg    <= pwdata[0];
                kswe_pkg::REG_HOMO_CUTOFF:    homo_cutoff_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rolling_kmer_reg  <= '0;
            good_bases_reg    <= '0;
            run_length_reg    <= '0;
            previous_base_reg <= '0;
            skipping_reg      <= 1'b0;
            skip_base_reg     <= '0;
            total_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                rolling_kmer_reg  <= rolling_kmer_next;
                previous_base_reg <= previous_base_next;
                skip_base_reg     <= skip_base_next;
                if (s_tlast) begin
                    good_bases_reg <= '0;
                    run_length_reg <= '0;
                    skipping_reg   <= 1'b0;
                    total_reg      <= '0;
                end else begin
                    good_bases_reg <= good_bases_next;
                    run_length_reg <= run_length_next;
                    skipping_reg   <= skipping_next;
                    total_reg      <= total_next;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_kmer_reg  <= out_kmer_next;
            out_count_reg <= total_next;
            out_valid_reg <= out_valid_next;
            out_start_reg <= out_start_next;
            out_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_kmer_reg};
    assign m_tuser  = {out_start_reg, out_valid_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### rtl/kswe_checker.sv
// Port-level checks for the k-mer extractor, bound to the top level.
// Depends on kswe_pkg and kmer_sliding_window_extractor.
`timescale 1ns / 1ps
`default_nettype none

module kswe_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [kswe_pkg::M_DATA_W-1:0]    m_tdata,
    input wire [1:0]                       m_tuser
);

    // Stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // Empty output stage always takes a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // Window start only on an emitted k-mer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("window start without k-mer");

    // No k-mer means zero k-mer field; an emitted k-mer is counted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] ? (m_tdata[77:62] != 16'd0) : (m_tdata[61:0] == 62'd0)))
        else $error("k-mer field and count disagree with valid flag");

endmodule

bind kmer_sliding_window_extractor kswe_checker u_kswe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
